// ===== design/bqc_pkg.sv =====
package bqc_pkg;

  // Operation codes carried by an input word.
  localparam logic [1:0] OP_FILTER = 2'd0;
  localparam logic [1:0] OP_COEF   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Coefficient slots inside one section.
  localparam logic [2:0] COEF_B0  = 3'd0;
  localparam logic [2:0] COEF_B1  = 3'd1;
  localparam logic [2:0] COEF_B2  = 3'd2;
  localparam logic [2:0] COEF_NA1 = 3'd3;
  localparam logic [2:0] COEF_NA2 = 3'd4;
  localparam int NUM_COEFS = 5;

  // Program counter of the sequencer.
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] STEP_FIRST = 4'd0;
  localparam logic [PC_W-1:0] STEP_EMIT  = 4'd11;

  typedef enum logic [0:0] {
    MUL_X  = 1'b0,
    MUL_YR = 1'b1
  } mul_src_t;

  typedef enum logic [1:0] {
    ACC_NOP     = 2'd0,
    ACC_LOAD_Z1 = 2'd1,
    ACC_LOAD_Z2 = 2'd2,
    ACC_ADD     = 2'd3
  } acc_op_t;

  typedef enum logic [1:0] {
    ACC2_NOP  = 2'd0,
    ACC2_LOAD = 2'd1,
    ACC2_ADD  = 2'd2
  } acc2_op_t;

  typedef enum logic [1:0] {
    FLOW_NEXT        = 2'd0,
    FLOW_SECTION_END = 2'd1,
    FLOW_EMIT        = 2'd2
  } flow_t;

  // One control word of the microprogram.
  typedef struct packed {
    logic [2:0] coef_sel;
    mul_src_t   mul_src;
    acc_op_t    acc_op;
    acc2_op_t   acc2_op;
    logic       y_sat;
    logic       yr_en;
    flow_t      flow;
  } ucode_t;

  // Microprogram for one section. A coefficient read issued in a step is
  // registered in coef_rd, multiplied into prod, rounded into pr and then summed.
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t uc;
    uc = '0;
    case (pc)
      4'd0: begin
        uc.coef_sel = COEF_B0;
      end
      4'd1: begin
        uc.coef_sel = COEF_B1;
        uc.mul_src  = MUL_X;
      end
      4'd2: begin
        uc.coef_sel = COEF_B2;
        uc.mul_src  = MUL_X;
      end
      4'd3: begin
        uc.mul_src = MUL_X;
        uc.acc_op  = ACC_LOAD_Z1;
      end
      4'd4: begin
        uc.y_sat  = 1'b1;
        uc.acc_op = ACC_LOAD_Z2;
      end
      4'd5: begin
        uc.yr_en    = 1'b1;
        uc.acc2_op  = ACC2_LOAD;
        uc.coef_sel = COEF_NA1;
      end
      4'd6: begin
        uc.coef_sel = COEF_NA2;
        uc.mul_src  = MUL_YR;
      end
      4'd7: begin
        uc.mul_src = MUL_YR;
      end
      4'd8: begin
        uc.acc_op = ACC_ADD;
      end
      4'd9: begin
        uc.acc2_op = ACC2_ADD;
      end
      4'd10: begin
        uc.flow = FLOW_SECTION_END;
      end
      4'd11: begin
        uc.flow = FLOW_EMIT;
      end
      default: begin
        uc.flow = FLOW_EMIT;
      end
    endcase
    return uc;
  endfunction

  // Clamp a 44-bit sum to 40 bits.
  function automatic logic [39:0] sat40(input logic [43:0] v);
    logic [39:0] r;
    if (v[43:39] == {5{v[43]}}) begin
      r = v[39:0];
    end else if (v[43]) begin
      r = {1'b1, 39'd0};
    end else begin
      r = {1'b0, {39{1'b1}}};
    end
    return r;
  endfunction

  // Clamp a 33-bit value to 32 bits.
  function automatic logic [31:0] sat32(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] == v[31]) begin
      r = v[31:0];
    end else if (v[32]) begin
      r = {1'b1, 31'd0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

  // Clamp a 32-bit value to 24 bits.
  function automatic logic [23:0] sat24(input logic [31:0] v);
    logic [23:0] r;
    if (v[31:23] == {9{v[31]}}) begin
      r = v[23:0];
    end else if (v[31]) begin
      r = {1'b1, 23'd0};
    end else begin
      r = {1'b0, {23{1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== design/biquad_cascade_filter.sv =====
// Cascade of transposed direct form II biquad sections in fixed point.
// Input channel (in_valid/in_ready) carries one word: op 0 filters
// sample_in, op 1 writes coef_value into coefficient coef_index of section
// section_index, op 2 zeroes all delay states, op 3 is dropped.
// Output channel (out_valid/out_ready) carries one word per filtered
// sample: sample_out saturated to Q1.23 and the saturated flag.
// The user is to write the section count through cfg_wr_en/cfg_wr_data only
// while idle; the block itself does not enforce this. 0 acts as 1 and values above MAX_SECTIONS act as MAX_SECTIONS.
// A sample runs through a microprogram of 11 steps per active section on
// one shared 32x32 multiplier, plus one step to load the output register;
// in_ready stays low until the sample's result is loaded into the output
// register, so no new word is taken while a sample is being filtered.
// Coefficient and clear words do not set busy and leave in_ready high.
// The output register holds a finished sample while the receiver stalls;
// the next word can still be accepted, but a new result waits in the last
// microprogram step until the register is free.
// Reset zeroes coefficients and states and sets the section count to 1.
module biquad_cascade_filter #(
  parameter int MAX_SECTIONS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [23:0] sample_in,
  input  logic [2:0]  section_index,
  input  logic [2:0]  coef_index,
  input  logic [31:0] coef_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] sample_out,
  output logic        saturated
);
  import bqc_pkg::*;

  localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int COEF_DEPTH = MAX_SECTIONS * NUM_COEFS;
  localparam int AW = $clog2(COEF_DEPTH);

  logic [3:0]      sec_count;
  logic            busy;
  logic [PC_W-1:0] pc;
  logic [SEC_W-1:0] sec;
  logic [SEC_W-1:0] last_sec;
  logic [AW-1:0]   coef_base;
  logic [AW-1:0]   rd_addr;
  logic [AW+2:0]   wr_addr_wide;
  logic [AW-1:0]   wr_addr;
  logic            accept;
  logic            coef_wr;
  logic            emit;
  ucode_t          ctl;
  logic [31:0]     coef_mem [COEF_DEPTH];
  logic            coef_vld [COEF_DEPTH];
  logic [31:0]     coef_rd;
  logic            coef_rd_vld;
  logic [31:0]     coef_q;
  logic [31:0]     x;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign ctl      = busy ? ucode(pc) : '0;
  assign emit     = busy && (ctl.flow == FLOW_EMIT) && (!out_valid || out_ready);

  // Index of the last active section after clamping the register.
  always_comb begin
    if (sec_count == 4'd0) begin
      last_sec = '0;
    end else if (int'(sec_count) > MAX_SECTIONS) begin
      last_sec = SEC_W'(MAX_SECTIONS - 1);
    end else begin
      last_sec = SEC_W'(sec_count - 4'd1);
    end
  end

  // Coefficient table: address is section * 5 + slot.
  assign wr_addr_wide = ({{AW{1'b0}}, section_index} << 2)
                      + {{AW{1'b0}}, section_index} + {{AW{1'b0}}, coef_index};
  assign wr_addr = wr_addr_wide[AW-1:0];
  assign coef_wr = accept && (op == OP_COEF)
                && (int'(section_index) < MAX_SECTIONS)
                && (coef_index < 3'(NUM_COEFS));
  assign rd_addr = coef_base + AW'(ctl.coef_sel);
  assign coef_q  = coef_rd_vld ? coef_rd : '0;

  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[wr_addr] <= coef_value;
    end
    coef_rd <= coef_mem[rd_addr];
  end

  // Valid bits stand in for the zero reset of the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COEF_DEPTH; i++) begin
        coef_vld[i] <= 1'b0;
      end
      coef_rd_vld <= 1'b0;
    end else begin
      if (coef_wr) begin
        coef_vld[wr_addr] <= 1'b1;
      end
      coef_rd_vld <= coef_vld[rd_addr];
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_count <= 4'd1;
    end else if (cfg_wr_en) begin
      sec_count <= cfg_wr_data;
    end
  end

  // Microprogram sequencer: step counter, section counter, jumps and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= STEP_FIRST;
      sec       <= '0;
      coef_base <= '0;
      out_valid <= 1'b0;
    end else begin
      // A finished sample loads the output word; otherwise it leaves when taken.
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept && (op == OP_FILTER)) begin
        busy      <= 1'b1;
        pc        <= STEP_FIRST;
        sec       <= '0;
        coef_base <= '0;
      end else if (busy) begin
        case (ctl.flow)
          FLOW_NEXT: begin
            pc <= pc + PC_W'(1);
          end
          FLOW_SECTION_END: begin
            if (sec == last_sec) begin
              pc <= STEP_EMIT;
            end else begin
              pc        <= STEP_FIRST;
              sec       <= sec + SEC_W'(1);
              coef_base <= coef_base + AW'(NUM_COEFS);
            end
          end
          FLOW_EMIT: begin
            if (emit) begin
              busy <= 1'b0;
            end
          end
          default: begin
            pc <= STEP_EMIT;
          end
        endcase
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (emit) begin
      sample_out <= sat24(x);
      saturated  <= (x[31:23] != {9{x[31]}});
    end
  end

  bqc_datapath #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sec    (sec),
    .coef   (coef_q),
    .start  (accept && (op == OP_FILTER)),
    .sample (sample_in),
    .clear  (accept && (op == OP_CLEAR)),
    .x      (x)
  );

`ifndef SYNTH
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (op == OP_FILTER)) |=> busy)
    else $error("filter word accepted but sequencer did not start");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pc <= STEP_EMIT))
    else $error("step counter left the microprogram");

  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (sec <= last_sec))
    else $error("section counter passed the last active section");

  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(busy) && !busy))
    else $error("result appeared without the sequencer finishing");

  a_jump: assert property (@(posedge clk) disable iff (rst)
    (busy && (ctl.flow == FLOW_SECTION_END)) |=> (pc == STEP_FIRST || pc == STEP_EMIT))
    else $error("bad jump at section end");
`endif

endmodule

// ===== design/bqc_datapath.sv =====
module bqc_datapath #(
  parameter int MAX_SECTIONS = 8,
  localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  bqc_pkg::ucode_t ctl,
  input  logic [SEC_W-1:0] sec,
  input  logic [31:0]     coef,
  input  logic            start,
  input  logic [23:0]     sample,
  input  logic            clear,
  output logic [31:0]     x
);
  import bqc_pkg::*;

  logic [63:0] prod;
  logic [63:0] prod_rnd;
  logic [41:0] pr;
  logic [43:0] pr_ext;
  logic [43:0] acc;
  logic [43:0] acc2;
  logic [39:0] y;
  logic [40:0] y_rnd;
  logic [31:0] yr;
  logic [31:0] mul_opnd;
  logic [39:0] z1 [MAX_SECTIONS];
  logic [39:0] z2 [MAX_SECTIONS];

  // The one multiplier, followed by a round-half-up to Q.31.
  assign mul_opnd = (ctl.mul_src == MUL_YR) ? yr : x;
  assign prod_rnd = prod + 64'd2097152;
  assign pr_ext   = {{2{pr[41]}}, pr};
  assign y_rnd    = {y[39], y} + 41'd128;

  always_ff @(posedge clk) begin
    prod <= 64'($signed(coef) * $signed(mul_opnd));
    pr   <= prod_rnd[63:22];
  end

  // Accumulators, section output and the signal passed between sections.
  always_ff @(posedge clk) begin
    case (ctl.acc_op)
      ACC_LOAD_Z1: acc <= pr_ext + {{4{z1[sec][39]}}, z1[sec]};
      ACC_LOAD_Z2: acc <= pr_ext + {{4{z2[sec][39]}}, z2[sec]};
      ACC_ADD:     acc <= acc + pr_ext;
      default:     acc <= acc;
    endcase
    case (ctl.acc2_op)
      ACC2_LOAD: acc2 <= pr_ext;
      ACC2_ADD:  acc2 <= acc2 + pr_ext;
      default:   acc2 <= acc2;
    endcase
    if (ctl.y_sat) begin
      y <= sat40(acc);
    end
    if (ctl.yr_en) begin
      yr <= sat32(y_rnd[40:8]);
    end
    if (start) begin
      x <= {{8{sample[23]}}, sample};
    end else if (ctl.flow == FLOW_SECTION_END) begin
      x <= yr;
    end
  end

  // Delay states: cleared by reset or a clear word, written at section end.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        z1[i] <= '0;
        z2[i] <= '0;
      end
    end else if (ctl.flow == FLOW_SECTION_END) begin
      z1[sec] <= sat40(acc);
      z2[sec] <= sat40(acc2);
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bqc_pkg::*;

  localparam int MAX_SEC = 8;
  localparam int RESET_CYCLES = 8;
  // Idle margin at the end of a drain, larger than the longest sample run.
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT = 20000;
  localparam int RAND_PHASES = 27;
  localparam int PHASE_WORDS = 45;
  localparam int DIR_ROWS = 25;
  localparam int MAX_SHOWN = 10;
  localparam longint ROUND_HALF = 64'sd2097152;

  // The op code that the block drops, and coefficient slots past the last one.
  localparam logic [1:0] OP_DROPPED = 2'd3;
  localparam logic [2:0] SLOT_PAST_END = 3'd5;
  localparam logic [2:0] SLOT_TOP = 3'd7;

  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] smp;
    logic [2:0]  sec;
    logic [2:0]  slot;
    logic [31:0] cv;
  } word_t;

  typedef struct packed {
    logic [23:0] smp;
    logic        clip;
  } filt_out_t;

  typedef struct packed {
    word_t     w;
    logic      typed;
    filt_out_t want;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_wr_data = 4'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = OP_FILTER;
  logic [23:0] sample_in = 24'd0;
  logic [2:0]  section_index = 3'd0;
  logic [2:0]  coef_index = COEF_B0;
  logic [31:0] coef_value = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] sample_out;
  logic        saturated;

  // Model state of the filter.
  logic [3:0] sections_reg = 4'd1;
  longint     coef_mem [MAX_SEC*NUM_COEFS];
  longint     z1_mem [MAX_SEC];
  longint     z2_mem [MAX_SEC];

  filt_out_t  due_samples [$];
  int         mismatches = 0;
  int         tx_idle_pct = 9;
  int         rx_idle_pct = 57;
  int         quiet_cycles = 0;

  // Directed words. Typed rows carry an answer that is obvious from the math;
  // the others go through the filter model.
  vector_t vectors [DIR_ROWS] = '{
    '{'{OP_FILTER, 24'h7FFFFF, 3'd0, COEF_B0, 32'h0}, 1'b1, '{24'h000000, 1'b0}},
    '{'{OP_FILTER, 24'h800000, 3'd0, COEF_B0, 32'h0}, 1'b1, '{24'h000000, 1'b0}},
    '{'{OP_COEF, 24'h0, 3'd0, COEF_B0, 32'h4000_0000}, 1'b0, '{24'h0, 1'b0}},
    '{'{OP_FILTER, 24'h7FFFFF, 3'd0, COEF_B0, 32'h0}, 1'b1, '{24'h7FFFFF, 1'b0}},
    '{'{OP_FILTER, 24'h800000, 3'd0, COEF_B0, 32'h0}, 1'b1, '{24'h800000, 1'b0}},
    '{'{OP_COEF, 24'h0, 3'd0, COEF_B0, 32'h8000_0000}, 1'b0, '{24'h0, 1'b0}},
    '{'{OP_FILTER, 24'h800000, 3'd0, COEF_B0, 32'h0}, 1'b1, '{24'h7FFFFF, 1'b1}},
    '{'{OP_FILTER, 24'h7FFFFF, 3'd0, COEF_B0, 32'h0}, 1'b1, '{24'h800000, 1'b1}},
    '{'{OP_COEF, 24'h0, 3'd0, COEF_B0, 32'h7FFF_FFFF}, 1'b0, '{24'h0, 1'b0}},
    '{'{OP_FILTER, 24'h7FFFFF, 3'd0, COEF_B0, 32'h0}, 1'b1, '{24'h7FFFFF, 1'b1}},
    '{'{OP_FILTER, 24'h000000, 3'd0, COEF_B0, 32'h0}, 1'b1, '{24'h000000, 1'b0}},
    '{'{OP_COEF, 24'h0, 3'd0, SLOT_PAST_END, 32'h0}, 1'b0, '{24'h0, 1'b0}},
    '{'{OP_COEF, 24'h0, 3'd0, SLOT_TOP, 32'hFFFF_FFFF}, 1'b0, '{24'h0, 1'b0}},
    '{'{OP_DROPPED, 24'h123456, 3'd7, SLOT_TOP, 32'h0}, 1'b0, '{24'h0, 1'b0}},
    '{'{OP_FILTER, 24'h000001, 3'd0, COEF_B0, 32'h0}, 1'b0, '{24'h0, 1'b0}},
    '{'{OP_COEF, 24'h0, 3'd0, COEF_B1, 32'h2000_0000}, 1'b0, '{24'h0, 1'b0}},
    '{'{OP_COEF, 24'h0, 3'd0, COEF_B2, 32'hE000_0000}, 1'b0, '{24'h0, 1'b0}},
    '{'{OP_COEF, 24'h0, 3'd0, COEF_NA1, 32'h3000_0000}, 1'b0, '{24'h0, 1'b0}},
    '{'{OP_COEF, 24'h0, 3'd0, COEF_NA2, 32'hD000_0000}, 1'b0, '{24'h0, 1'b0}},
    '{'{OP_COEF, 24'h0, 3'd7, COEF_B0, 32'h4000_0000}, 1'b0, '{24'h0, 1'b0}},
    '{'{OP_FILTER, 24'h400000, 3'd0, COEF_B0, 32'h0}, 1'b0, '{24'h0, 1'b0}},
    '{'{OP_FILTER, 24'hFFFFFF, 3'd0, COEF_B0, 32'h0}, 1'b0, '{24'h0, 1'b0}},
    '{'{OP_CLEAR, 24'h0, 3'd0, COEF_B0, 32'h0}, 1'b0, '{24'h0, 1'b0}},
    '{'{OP_FILTER, 24'h400000, 3'd0, COEF_B0, 32'h0}, 1'b0, '{24'h0, 1'b0}},
    '{'{OP_FILTER, 24'h000000, 3'd0, COEF_B0, 32'h0}, 1'b0, '{24'h0, 1'b0}}
  };

  biquad_cascade_filter #(
    .MAX_SECTIONS(MAX_SEC)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .sample_in(sample_in),
    .section_index(section_index),
    .coef_index(coef_index),
    .coef_value(coef_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample_out(sample_out),
    .saturated(saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Section count actually used: zero acts as one, large values are capped.
  function automatic int active_sections(input logic [3:0] cfg);
    int n;
    n = int'(cfg);
    if (n < 1) begin
      n = 1;
    end
    if (n > MAX_SEC) begin
      n = MAX_SEC;
    end
    return n;
  endfunction

  function automatic longint clamp_to(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end
    if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // Q2.30 coefficient times Q9.23 signal, rounded half up to Q.31.
  function automatic longint scaled_product(input longint c, input longint s);
    return (c * s + ROUND_HALF) >>> 22;
  endfunction

  // Applies one accepted word to the filter model and gives the filtered
  // sample it produces, if any.
  task automatic filter_word(input word_t w, output logic has_out,
                             output filt_out_t res);
    longint x;
    longint y;
    longint yr;
    longint z1n;
    longint z2n;
    longint o;
    int base;
    has_out = 1'b0;
    res = '0;
    case (w.op)
      OP_COEF: begin
        if (w.sec < MAX_SEC && w.slot < NUM_COEFS) begin
          coef_mem[w.sec*NUM_COEFS + w.slot] = longint'($signed(w.cv));
        end
      end
      OP_CLEAR: begin
        for (int k = 0; k < MAX_SEC; k++) begin
          z1_mem[k] = 0;
          z2_mem[k] = 0;
        end
      end
      OP_FILTER: begin
        x = longint'($signed(w.smp));
        for (int k = 0; k < active_sections(sections_reg); k++) begin
          base = k * NUM_COEFS;
          y = clamp_to(scaled_product(coef_mem[base + COEF_B0], x) + z1_mem[k], 40);
          yr = clamp_to((y + 128) >>> 8, 32);
          z1n = clamp_to(scaled_product(coef_mem[base + COEF_NA1], yr) +
                         scaled_product(coef_mem[base + COEF_B1], x) + z2_mem[k], 40);
          z2n = clamp_to(scaled_product(coef_mem[base + COEF_B2], x) +
                         scaled_product(coef_mem[base + COEF_NA2], yr), 40);
          z1_mem[k] = z1n;
          z2_mem[k] = z2n;
          x = yr;
        end
        o = clamp_to(x, 24);
        res.smp = o[23:0];
        res.clip = (o != x);
        has_out = 1'b1;
      end
      default: begin
      end
    endcase
  endtask

  // Presents one word, waits for its handshake and records what it should
  // produce. Valid stays high after acceptance so back-to-back words never
  // see a low pulse.
  task automatic send_word(input word_t w, input logic typed, input filt_out_t want);
    logic has_out;
    filt_out_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= w.op;
    sample_in <= w.smp;
    section_index <= w.sec;
    coef_index <= w.slot;
    coef_value <= w.cv;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    filter_word(w, has_out, res);
    if (has_out) begin
      due_samples.push_back(typed ? want : res);
    end
  endtask

  // Waits until every filtered sample has come out and the sequencer is done.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_sections(input logic [3:0] n);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sections_reg = n;
  endtask

  function automatic logic [23:0] rand_sample();
    logic [31:0] raw;
    int unsigned pick;
    raw = $urandom;
    pick = $urandom_range(99);
    if (pick < 5) begin
      return 24'h7FFFFF;
    end
    if (pick < 10) begin
      return 24'h800000;
    end
    if (pick < 20) begin
      return {{12{raw[11]}}, raw[11:0]};
    end
    return raw[23:0];
  endfunction

  // Mostly coefficients of at most one quarter in magnitude, so the cascade does not
  // sit in saturation all the time; the rest span the full range.
  function automatic logic [31:0] rand_coef();
    logic [31:0] raw;
    raw = $urandom;
    if ($urandom_range(99) < 70) begin
      return {{3{raw[28]}}, raw[28:0]};
    end
    return raw;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int unsigned pick;
    w.smp = rand_sample();
    w.sec = 3'($urandom_range(MAX_SEC - 1));
    w.slot = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                      : 3'($urandom_range(NUM_COEFS - 1));
    w.cv = rand_coef();
    pick = $urandom_range(99);
    if (pick < 65) begin
      w.op = OP_FILTER;
    end else if (pick < 87) begin
      w.op = OP_COEF;
    end else if (pick < 95) begin
      w.op = OP_CLEAR;
    end else begin
      w.op = OP_DROPPED;
    end
    return w;
  endfunction

  // Output side: checks each filtered word and stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("ERROR: unexpected filtered word sample_out %h saturated %b",
                     sample_out, saturated);
          end
        end else if (due_samples[0].smp !== sample_out ||
                     due_samples[0].clip !== saturated) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("ERROR: expected sample_out %h saturated %b, got %h %b",
                     due_samples[0].smp, due_samples[0].clip, sample_out, saturated);
          end
          void'(due_samples.pop_front());
        end else begin
          void'(due_samples.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    word_t w;
    logic [3:0] n;
    int mode;
    for (int i = 0; i < MAX_SEC*NUM_COEFS; i++) begin
      coef_mem[i] = 0;
    end
    for (int k = 0; k < MAX_SEC; k++) begin
      z1_mem[k] = 0;
      z2_mem[k] = 0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words with one section active, as after reset.
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(vectors[i].w, vectors[i].typed, vectors[i].want);
    end

    // Random phases: set the section count, load every active section, then
    // mix samples, coefficient writes, clears and dropped words.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      mode = ph * 3 / RAND_PHASES;
      tx_idle_pct = (mode == 0) ? 9 : ((mode == 1) ? 57 : 0);
      rx_idle_pct = (mode == 0) ? 57 : ((mode == 1) ? 9 : 0);
      case (ph)
        0: n = 4'd1;
        1: n = 4'd8;
        2: n = 4'd0;
        3: n = 4'd15;
        4: n = 4'd9;
        default: begin
          n = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 4));
        end
      endcase
      drain();
      write_sections(n);
      for (int k = 0; k < active_sections(n); k++) begin
        for (int s = 0; s < NUM_COEFS; s++) begin
          w = rand_word();
          w.op = OP_COEF;
          w.sec = 3'(k);
          w.slot = 3'(s);
          send_word(w, 1'b0, '0);
        end
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        send_word(rand_word(), 1'b0, '0);
      end
    end

    drain();
    if (mismatches == 0 && due_samples.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
